@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file pli_checker.sv.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define PLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition never holds on a clock edge outside reset.
`define PLI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hdl/pli_pkg.sv @@
// Types and codes for the positional list block.
// Used by positional_list_insert_remove_top and pli_checker; depends on nothing.
package pli_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_PUT,
    ST_RM_TAKE,
    ST_RM_GRAB,
    ST_RM_RD,
    ST_RM_WR,
    ST_RM_END,
    ST_DONE
  } state_e;

endpackage

@@ hdl/positional_list_insert_remove_top.sv @@
// Positional list: insert shifts entries from the tail down to the position up one slot, then
// writes the item; remove takes the entry there and pulls later ones down; clear or a refused
// command goes straight to done_o. Entries move through the memory's single read and write port.
// busy_o stays high until the done_o beat; a new command is taken the cycle after it.
// rst_ni (async, active low) empties the list; entry contents stay undefined until written.
// Results are shown for one cycle on done_o; the receiver cannot stall them.
module positional_list_insert_remove_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         position_i,
  input  logic signed [31:0] item_value_i,
  output logic               done_o,
  output logic               ok_o,
  output logic signed [31:0] removed_value_o,
  output logic [4:0]         item_count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pli_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [31:0]   val_q, val_d;
  logic          ok_q, ok_d;
  logic [31:0]   taken_q, taken_d;

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rd_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;

  logic [31:0]   cnt_ext, pos_ext, cur_ext;
  logic [AW-1:0] count_idx, pos_idx, cur_dn, cur_up;
  logic          ins_ok, rem_ok;

  assign cnt_ext   = 32'(count_q);
  assign pos_ext   = 32'(position_i);
  assign cur_ext   = 32'(cur_q);
  assign count_idx = cnt_ext[AW-1:0];
  assign pos_idx   = pos_ext[AW-1:0];
  assign cur_dn    = cur_q - 1'b1;
  assign cur_up    = cur_q + 1'b1;

  assign ins_ok = (count_q == '0 && position_i == 4'd0) ||
                  (cnt_ext < 32'(DEPTH) && pos_ext < cnt_ext);
  assign rem_ok = pos_ext < cnt_ext;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pli_pkg::ST_IDLE;
      count_q <= '0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    val_q   <= val_d;
    ok_q    <= ok_d;
    taken_q <= taken_d;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    cur_d   = cur_q;
    pos_d   = pos_q;
    val_d   = val_q;
    ok_d    = ok_q;
    taken_d = taken_q;
    rd_en   = 1'b0;
    rd_addr = cur_q;
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = rd_q;

    unique case (state_q)
      pli_pkg::ST_IDLE: begin
        if (start_i) begin
          pos_d   = pos_idx;
          val_d   = item_value_i;
          ok_d    = 1'b0;
          taken_d = '0;
          state_d = pli_pkg::ST_DONE;
          unique case (mode_i)
            pli_pkg::MODE_INSERT: begin
              if (ins_ok) begin
                cur_d   = count_idx;
                state_d = (count_idx == pos_idx) ? pli_pkg::ST_PUT : pli_pkg::ST_INS_RD;
              end
            end
            pli_pkg::MODE_REMOVE: begin
              if (rem_ok) begin
                state_d = pli_pkg::ST_RM_TAKE;
              end
            end
            pli_pkg::MODE_CLEAR: begin
              count_d = '0;
              ok_d    = 1'b1;
            end
            default: ;
          endcase
        end
      end
      // move entries up from the tail toward the insert slot
      pli_pkg::ST_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur_dn;
        state_d = pli_pkg::ST_INS_WR;
      end
      pli_pkg::ST_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = cur_q;
        wr_data = rd_q;
        cur_d   = cur_dn;
        state_d = (cur_dn == pos_q) ? pli_pkg::ST_PUT : pli_pkg::ST_INS_RD;
      end
      pli_pkg::ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = val_q;
        count_d = CW'(count_q + 1'b1);
        ok_d    = 1'b1;
        state_d = pli_pkg::ST_DONE;
      end
      pli_pkg::ST_RM_TAKE: begin
        rd_en   = 1'b1;
        rd_addr = pos_q;
        cur_d   = pos_q;
        state_d = pli_pkg::ST_RM_GRAB;
      end
      pli_pkg::ST_RM_GRAB: begin
        taken_d = rd_q;
        state_d = (cur_ext + 32'd2 <= cnt_ext) ? pli_pkg::ST_RM_RD : pli_pkg::ST_RM_END;
      end
      // close the gap: pull each later entry down by one
      pli_pkg::ST_RM_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur_up;
        state_d = pli_pkg::ST_RM_WR;
      end
      pli_pkg::ST_RM_WR: begin
        wr_en   = 1'b1;
        wr_addr = cur_q;
        wr_data = rd_q;
        cur_d   = cur_up;
        state_d = (cur_ext + 32'd3 <= cnt_ext) ? pli_pkg::ST_RM_RD : pli_pkg::ST_RM_END;
      end
      pli_pkg::ST_RM_END: begin
        count_d = CW'(count_q - 1'b1);
        ok_d    = 1'b1;
        state_d = pli_pkg::ST_DONE;
      end
      pli_pkg::ST_DONE: begin
        state_d = pli_pkg::ST_IDLE;
      end
      default: begin
        state_d = pli_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o          = (state_q != pli_pkg::ST_IDLE);
  assign done_o          = (state_q == pli_pkg::ST_DONE);
  assign ok_o            = ok_q;
  assign removed_value_o = signed'(taken_q);
  assign item_count_o    = cnt_ext[4:0];

endmodule

@@ hdl/pli_checker.sv @@
// Port-level checks for positional_list_insert_remove_top, bound to the top level.
// Depends on assert_macros.svh and pli_pkg.
`include "assert_macros.svh"

module pli_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  mode_i,
  input logic        done_o,
  input logic        ok_o,
  input logic [31:0] removed_value_o,
  input logic [4:0]  item_count_o
);

  // an accepted command keeps the block busy until its result beat
  `PLI_ASSERT(a_accept_busy, start_i && !busy_o |=> busy_o, "accepted command did not raise busy")
  // the result beat ends the command
  `PLI_ASSERT(a_done_release, done_o |=> !busy_o && !done_o, "busy held after result beat")
  // a refused command never reports a removed value
  `PLI_NEVER(a_refused_zero, done_o && !ok_o && removed_value_o != 32'd0,
    "refused command reported a value")
  // clear always succeeds and empties the list
  `PLI_ASSERT(a_clear, start_i && !busy_o && mode_i == pli_pkg::MODE_CLEAR |=>
    (done_o && ok_o && item_count_o == 5'd0), "clear did not empty the list")
  // no result beat without a command in flight
  `PLI_NEVER(a_done_idle, done_o && !busy_o, "result beat while idle")

endmodule

bind positional_list_insert_remove_top pli_checker u_pli_checker (.*);
